// ===== rtl/irfp_pkg.sv =====
// Package for the infrared ranger filter with presence detection.
// Holds register codes, reset values, divider constants and the sequencer state type.
// No dependencies.
package irfp_pkg;

   // Default number of ranger channels
   localparam int CHANNELS_DEFAULT = 4;
   // Widest channel index that the channel count range allows
   localparam int MAX_CH_W = 4;

   // Input item kinds
   localparam logic [1:0] KIND_SAMPLE = 2'd0;
   localparam logic [1:0] KIND_TICK   = 2'd1;
   localparam logic [1:0] KIND_CLEAR  = 2'd2;

   // Register indexes
   localparam logic [2:0] CSR_MIN_RANGE      = 3'd0;
   localparam logic [2:0] CSR_MAX_RANGE      = 3'd1;
   localparam logic [2:0] CSR_MAX_SLEW       = 3'd2;
   localparam logic [2:0] CSR_NEAR_THRESHOLD = 3'd3;
   localparam logic [2:0] CSR_DEADBAND       = 3'd4;
   localparam logic [2:0] CSR_ABSENT_ROUNDS  = 3'd5;

   // Register reset values
   localparam logic [15:0] MIN_RANGE_RESET      = 16'd2560;
   localparam logic [15:0] MAX_RANGE_RESET      = 16'd38400;
   localparam logic [15:0] MAX_SLEW_RESET       = 16'd6400;
   localparam logic [15:0] NEAR_THRESHOLD_RESET = 16'd25600;
   localparam logic [15:0] DEADBAND_RESET       = 16'd77;
   localparam logic [7:0]  ABSENT_ROUNDS_RESET  = 8'd10;

   // Stored channel distance after reset
   localparam logic [15:0] DISTANCE_RESET = 16'd38400;

   // Distance = DIV_NUMERATOR / (sample - SAMPLE_OFFSET)
   localparam int          DIV_W         = 24;
   localparam logic [23:0] DIV_NUMERATOR = 24'd8850432;
   localparam logic [11:0] SAMPLE_OFFSET = 12'd521;

   // Direction code when no channel qualifies
   localparam logic [2:0] DIR_NONE = 3'b111;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_FILT_A,
      ST_FILT_B,
      ST_SCAN,
      ST_FINISH
   } state_type;

endpackage

// ===== rtl/ir_range_filter_presence.sv =====
// Infrared ranger filter with presence detection, top level.
// Shared restoring divider, filter steps and a channel scan under one sequencer.
// Depends on irfp_pkg.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+---------------------
//  request | req_kind, req_adc_sample                | req_valid / req_stall
//  result  | rsp_channel .. rsp_lost_ms              | rsp_valid / rsp_stall
//  csr     | csr_index, csr_data                     | csr_valid / csr_ready
//
// Sample item above the offset: 24 divider steps, one bit a cycle, then the filter
// steps FILT_A and FILT_B, one scan cycle per channel and the finish step.
// Sample at or below the offset: no divider steps. Tick, clear, other: scan and finish.
// Reset is synchronous; no clearing pass, the block is ready as soon as reset is released.
// A stalled result holds in the output register; the next item is accepted meanwhile,
// and the finish cycle waits until the output register is free.
module ir_range_filter_presence #(
   parameter int CHANNELS = irfp_pkg::CHANNELS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_kind,
   input  logic [11:0]        req_adc_sample,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_channel,
   output logic [15:0]        rsp_distance,
   output logic               rsp_round_done,
   output logic               rsp_object_present,
   output logic [15:0]        rsp_nearest,
   output logic signed [2:0]  rsp_direction,
   output logic [31:0]        rsp_lost_ms,
   // configuration channel
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data
);
   import irfp_pkg::*;

   localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int STEP_W = $clog2(DIV_W);

   // sequencer
   state_type state_ff, state_in;

   // configuration registers
   logic [15:0] min_range_ff, min_range_in;
   logic [15:0] max_range_ff, max_range_in;
   logic [15:0] max_slew_ff, max_slew_in;
   logic [15:0] near_thr_ff, near_thr_in;
   logic [15:0] deadband_ff, deadband_in;
   logic [7:0]  absent_rounds_ff, absent_rounds_in;

   // channel and detection state
   logic [15:0]     dist_ff [CHANNELS];
   logic [15:0]     dist_in [CHANNELS];
   logic [CH_W-1:0] next_ch_ff, next_ch_in;
   logic            present_ff, present_in;
   logic [7:0]      empty_cnt_ff, empty_cnt_in;
   logic [31:0]     since_lost_ff, since_lost_in;

   // per-item working registers
   logic [CH_W-1:0]   cur_ch_ff, cur_ch_in;
   logic              is_sample_ff, is_sample_in;
   logic              done_ff, done_in;
   logic [11:0]       divisor_ff, divisor_in;
   logic [11:0]       rem_ff, rem_in;
   logic [DIV_W-1:0]  quot_ff, quot_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [16:0]       dslew_ff, dslew_in;
   logic [CH_W-1:0]   scan_idx_ff, scan_idx_in;
   logic              any_ff, any_in;
   logic [15:0]       nearest_ff, nearest_in;
   logic [15:0]       dmin_ff, dmin_in;
   logic [2:0]        dir_ff, dir_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_channel_ff, rsp_channel_in;
   logic [15:0] rsp_distance_ff, rsp_distance_in;
   logic        rsp_round_done_ff, rsp_round_done_in;
   logic        rsp_present_ff, rsp_present_in;
   logic [15:0] rsp_nearest_ff, rsp_nearest_in;
   logic [2:0]  rsp_direction_ff, rsp_direction_in;
   logic [31:0] rsp_lost_ms_ff, rsp_lost_ms_in;

   // shared read port of the channel distances
   logic [CH_W-1:0] rd_addr;
   logic [15:0]     rd_data;

   // datapath temporaries
   logic [12:0]         rem_sh;
   logic                q_bit;
   logic [DIV_W-1:0]    d_lo;
   logic [DIV_W-1:0]    d_cl;
   logic [15:0]         d16;
   logic [15:0]         step_up;
   logic [15:0]         step_dn;
   logic [17:0]         sum18;
   logic [16:0]         avg17;
   logic [16:0]         mag17;
   logic [15:0]         filt_out;
   logic [MAX_CH_W-1:0] ch_wide;
   logic [MAX_CH_W-1:0] idx_wide;
   logic [7:0]          cnt_sat;
   logic                ev_present;
   logic [7:0]          ev_empty;
   logic [31:0]         ev_lost;
   logic                out_free;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // select the distance read address: scan index while scanning, else the item's channel
   assign rd_addr = (state_ff == ST_SCAN) ? scan_idx_ff : cur_ch_ff;
   assign rd_data = dist_ff[rd_addr];

   assign ch_wide  = MAX_CH_W'(cur_ch_ff);
   assign idx_wide = MAX_CH_W'(scan_idx_ff);

   // divider step: shift in the next numerator bit, subtract if it fits
   always_comb begin
      rem_sh = {rem_ff, quot_ff[DIV_W-1]};
      q_bit  = (rem_sh >= {1'b0, divisor_ff});
   end

   // clamp and slew limit against the stored distance
   always_comb begin
      d_lo    = (quot_ff < DIV_W'(min_range_ff)) ? DIV_W'(min_range_ff) : quot_ff;
      d_cl    = (d_lo > DIV_W'(max_range_ff)) ? DIV_W'(max_range_ff) : d_lo;
      d16     = d_cl[15:0];
      step_up = d16 - rd_data;
      step_dn = rd_data - d16;
   end

   // average with the stored distance and apply the deadband
   always_comb begin
      sum18 = 18'(rd_data) + 18'(dslew_ff);
      avg17 = sum18[17:1];
      if (avg17 >= 17'(rd_data)) begin
         mag17 = avg17 - 17'(rd_data);
      end else begin
         mag17 = 17'(rd_data) - avg17;
      end
      if (mag17 < 17'(deadband_ff)) begin
         filt_out = rd_data;
      end else begin
         filt_out = avg17[15:0];
      end
   end

   // round evaluation of the presence flag
   always_comb begin
      cnt_sat    = (empty_cnt_ff != 8'hFF) ? (empty_cnt_ff + 8'd1) : empty_cnt_ff;
      ev_present = present_ff;
      ev_empty   = empty_cnt_ff;
      ev_lost    = since_lost_ff;
      if (done_ff) begin
         if (any_ff) begin
            if (!present_ff) begin
               ev_present = 1'b1;
               ev_empty   = 8'd0;
            end
         end else begin
            ev_empty = cnt_sat;
            if ((cnt_sat >= absent_rounds_ff) && present_ff) begin
               ev_present = 1'b0;
               ev_lost    = 32'd0;
               ev_empty   = 8'd0;
            end
         end
      end
   end

   // sequencer: next state, working registers and outputs
   always_comb begin
      state_in          = state_ff;
      min_range_in      = min_range_ff;
      max_range_in      = max_range_ff;
      max_slew_in       = max_slew_ff;
      near_thr_in       = near_thr_ff;
      deadband_in       = deadband_ff;
      absent_rounds_in  = absent_rounds_ff;
      dist_in           = dist_ff;
      next_ch_in        = next_ch_ff;
      present_in        = present_ff;
      empty_cnt_in      = empty_cnt_ff;
      since_lost_in     = since_lost_ff;
      cur_ch_in         = cur_ch_ff;
      is_sample_in      = is_sample_ff;
      done_in           = done_ff;
      divisor_in        = divisor_ff;
      rem_in            = rem_ff;
      quot_in           = quot_ff;
      step_in           = step_ff;
      dslew_in          = dslew_ff;
      scan_idx_in       = scan_idx_ff;
      any_in            = any_ff;
      nearest_in        = nearest_ff;
      dmin_in           = dmin_ff;
      dir_in            = dir_ff;
      rsp_valid_in      = rsp_valid_ff;
      rsp_channel_in    = rsp_channel_ff;
      rsp_distance_in   = rsp_distance_ff;
      rsp_round_done_in = rsp_round_done_ff;
      rsp_present_in    = rsp_present_ff;
      rsp_nearest_in    = rsp_nearest_ff;
      rsp_direction_in  = rsp_direction_ff;
      rsp_lost_ms_in    = rsp_lost_ms_ff;

      // drop a delivered result
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // take register writes
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MIN_RANGE:      min_range_in     = csr_data;
            CSR_MAX_RANGE:      max_range_in     = csr_data;
            CSR_MAX_SLEW:       max_slew_in      = csr_data;
            CSR_NEAR_THRESHOLD: near_thr_in      = csr_data;
            CSR_DEADBAND:       deadband_in      = csr_data;
            CSR_ABSENT_ROUNDS:  absent_rounds_in = csr_data[7:0];
            default:            ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               // start the scan accumulators for this item
               scan_idx_in  = '0;
               any_in       = 1'b0;
               nearest_in   = max_range_ff;
               dmin_in      = max_range_ff;
               dir_in       = DIR_NONE;
               cur_ch_in    = next_ch_ff;
               done_in      = 1'b0;
               is_sample_in = (req_kind == KIND_SAMPLE);
               state_in     = ST_SCAN;
               case (req_kind)
                  KIND_SAMPLE: begin
                     if (req_adc_sample > SAMPLE_OFFSET) begin
                        divisor_in = req_adc_sample - SAMPLE_OFFSET;
                        rem_in     = '0;
                        quot_in    = DIV_NUMERATOR;
                        step_in    = '0;
                        state_in   = ST_DIVIDE;
                     end else begin
                        quot_in  = DIV_W'(max_range_ff);
                        state_in = ST_FILT_A;
                     end
                  end
                  KIND_TICK: begin
                     if (since_lost_ff != 32'hFFFF_FFFF) begin
                        since_lost_in = since_lost_ff + 32'd1;
                     end
                  end
                  KIND_CLEAR: begin
                     present_in    = 1'b0;
                     empty_cnt_in  = 8'd0;
                     since_lost_in = 32'd0;
                  end
                  default: ;
               endcase
            end
         end

         ST_DIVIDE: begin
            // one quotient bit per cycle
            if (q_bit) begin
               rem_in = 12'(rem_sh - {1'b0, divisor_ff});
            end else begin
               rem_in = rem_sh[11:0];
            end
            quot_in = {quot_ff[DIV_W-2:0], q_bit};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(DIV_W - 1)) begin
               state_in = ST_FILT_A;
            end
         end

         ST_FILT_A: begin
            // clamp, then limit the change to max_slew either way
            dslew_in = {1'b0, d16};
            if ((d16 > rd_data) && (step_up > max_slew_ff)) begin
               dslew_in = 17'(rd_data) + 17'(max_slew_ff);
            end else if ((rd_data > d16) && (step_dn > max_slew_ff)) begin
               dslew_in = 17'(rd_data) - 17'(max_slew_ff);
            end
            state_in = ST_FILT_B;
         end

         ST_FILT_B: begin
            // store the filtered distance and advance the channel
            dist_in[cur_ch_ff] = filt_out;
            if (cur_ch_ff == CH_W'(CHANNELS - 1)) begin
               next_ch_in = '0;
               done_in    = 1'b1;
            end else begin
               next_ch_in = cur_ch_ff + CH_W'(1);
            end
            state_in = ST_SCAN;
         end

         ST_SCAN: begin
            // one stored distance per cycle
            if (rd_data < near_thr_ff) begin
               any_in = 1'b1;
            end
            if (rd_data < nearest_ff) begin
               nearest_in = rd_data;
            end
            if ((rd_data < dmin_ff) && (rd_data < near_thr_ff)) begin
               dmin_in = rd_data;
               dir_in  = idx_wide[2:0];
            end
            if (scan_idx_ff == CH_W'(CHANNELS - 1)) begin
               scan_idx_in = '0;
               state_in    = ST_FINISH;
            end else begin
               scan_idx_in = scan_idx_ff + CH_W'(1);
            end
         end

         ST_FINISH: begin
            // commit the round evaluation and load the result once the output is free
            if (out_free) begin
               present_in        = ev_present;
               empty_cnt_in      = ev_empty;
               since_lost_in     = ev_lost;
               rsp_valid_in      = 1'b1;
               rsp_channel_in    = is_sample_ff ? ch_wide[1:0] : 2'd0;
               rsp_distance_in   = is_sample_ff ? dist_ff[cur_ch_ff] : 16'd0;
               rsp_round_done_in = done_ff;
               rsp_present_in    = ev_present;
               rsp_nearest_in    = nearest_ff;
               rsp_direction_in  = ev_present ? dir_ff : DIR_NONE;
               rsp_lost_ms_in    = ev_present ? 32'd0 : ev_lost;
               state_in          = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         min_range_ff     <= MIN_RANGE_RESET;
         max_range_ff     <= MAX_RANGE_RESET;
         max_slew_ff      <= MAX_SLEW_RESET;
         near_thr_ff      <= NEAR_THRESHOLD_RESET;
         deadband_ff      <= DEADBAND_RESET;
         absent_rounds_ff <= ABSENT_ROUNDS_RESET;
         for (int i = 0; i < CHANNELS; i++) begin
            dist_ff[i] <= DISTANCE_RESET;
         end
         next_ch_ff    <= '0;
         present_ff    <= 1'b0;
         empty_cnt_ff  <= 8'd0;
         since_lost_ff <= 32'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff         <= state_in;
         min_range_ff     <= min_range_in;
         max_range_ff     <= max_range_in;
         max_slew_ff      <= max_slew_in;
         near_thr_ff      <= near_thr_in;
         deadband_ff      <= deadband_in;
         absent_rounds_ff <= absent_rounds_in;
         dist_ff          <= dist_in;
         next_ch_ff       <= next_ch_in;
         present_ff       <= present_in;
         empty_cnt_ff     <= empty_cnt_in;
         since_lost_ff    <= since_lost_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      cur_ch_ff         <= cur_ch_in;
      is_sample_ff      <= is_sample_in;
      done_ff           <= done_in;
      divisor_ff        <= divisor_in;
      rem_ff            <= rem_in;
      quot_ff           <= quot_in;
      step_ff           <= step_in;
      dslew_ff          <= dslew_in;
      scan_idx_ff       <= scan_idx_in;
      any_ff            <= any_in;
      nearest_ff        <= nearest_in;
      dmin_ff           <= dmin_in;
      dir_ff            <= dir_in;
      rsp_channel_ff    <= rsp_channel_in;
      rsp_distance_ff   <= rsp_distance_in;
      rsp_round_done_ff <= rsp_round_done_in;
      rsp_present_ff    <= rsp_present_in;
      rsp_nearest_ff    <= rsp_nearest_in;
      rsp_direction_ff  <= rsp_direction_in;
      rsp_lost_ms_ff    <= rsp_lost_ms_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_channel        = rsp_channel_ff;
   assign rsp_distance       = rsp_distance_ff;
   assign rsp_round_done     = rsp_round_done_ff;
   assign rsp_object_present = rsp_present_ff;
   assign rsp_nearest        = rsp_nearest_ff;
   assign rsp_direction      = signed'(rsp_direction_ff);
   assign rsp_lost_ms        = rsp_lost_ms_ff;

   // divider remainder stays below the divisor
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (rem_ff < divisor_ff))
      else $error("divider remainder not below divisor");

   // a completed round always comes from the last channel
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_round_done) |->
         (rsp_channel == 2'(MAX_CH_W'(CHANNELS - 1))))
      else $error("round done on a channel other than the last");

   // while present the loss timer reads zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_object_present) |-> (rsp_lost_ms == 32'd0))
      else $error("lost time reported while present");

   // a new result is loaded only from the finish cycle
   assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid)) |-> ($past(state_ff) == ST_FINISH))
      else $error("result loaded outside the finish cycle");

endmodule
